// ----- src/brlrr_pkg.sv -----
// Shared types and codes of the burst limited round robin queues unit.
package brlrr_pkg;

	localparam int NUM_DIRS = 4;
	localparam int DIR_W = 2;
	localparam int TAG_W = 16;
	localparam int TIME_W = 8;
	localparam int LIMIT_W = 8;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_INDEX_W = 1;

	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_SERVE = 1'b1;

	localparam logic [1:0] ST_GRANTED = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_ENQUEUED = 2'd2;
	localparam logic [1:0] ST_DROPPED = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_START_DIRECTION = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BURST_LIMIT = 1'd1;

	typedef struct packed {
		logic operation;
		logic [DIR_W-1:0] direction;
		logic [TAG_W-1:0] car_tag;
		logic [TIME_W-1:0] pass_time;
	} req_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [DIR_W-1:0] granted_direction;
		logic [TAG_W-1:0] granted_tag;
		logic [TIME_W-1:0] granted_time;
	} rsp_item_t;

	typedef struct packed {
		logic load_item;
		logic execute;
		logic load_out;
	} dp_cmd_t;

endpackage

// ----- src/brlrr_ctrl.sv -----
// Controller state machine that sequences one transaction at a time.
module brlrr_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input logic rsp_ready,
	output brlrr_pkg::dp_cmd_t cmd
);
	import brlrr_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_OUT
	} state_t;

	state_t state_q;
	logic rsp_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd.load_item = req_valid && (state_q == S_IDLE);
		cmd.execute = (state_q == S_EXEC);
		cmd.load_out = (state_q == S_OUT) && (!rsp_valid_q || rsp_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (cmd.load_out) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/brlrr_dp.sv -----
// Datapath: queue pointers and counts, car store, direction pick and result register.
module brlrr_dp #(
	parameter int QUEUE_DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	input brlrr_pkg::dp_cmd_t cmd,
	input brlrr_pkg::req_item_t req,
	output brlrr_pkg::rsp_item_t rsp,
	input logic cfg_we,
	input logic [brlrr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [brlrr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import brlrr_pkg::*;

	localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = DIR_W + SW;
	localparam int MEM_DEPTH = NUM_DIRS << SW;
	localparam int ENTRY_W = TAG_W + TIME_W;

	req_item_t item_q;
	logic [DIR_W-1:0] start_dir_q;
	logic [LIMIT_W-1:0] burst_limit_q;
	logic [SW-1:0] heads_q [NUM_DIRS];
	logic [CW-1:0] counts_q [NUM_DIRS];
	logic [DIR_W-1:0] cur_dir_q;
	logic [LIMIT_W-1:0] burst_served_q;
	logic fresh_q;
	logic [1:0] status_q;
	logic [DIR_W-1:0] pick_dir_q;
	logic [ENTRY_W-1:0] rdata_q;
	rsp_item_t rsp_q;

	logic [ENTRY_W-1:0] mem [MEM_DEPTH];

	logic [NUM_DIRS-1:0] nonempty;
	logic [LIMIT_W-1:0] limit;
	logic [LIMIT_W-1:0] used;
	logic stay;
	logic [DIR_W-1:0] base;
	logic found;
	logic [DIR_W-1:0] pick;
	logic [DIR_W-1:0] probe;
	logic [LIMIT_W-1:0] new_served;
	logic enq_full;
	logic [SW:0] tail_sum;
	logic [SW-1:0] tail_slot;
	logic [SW-1:0] head_next;
	logic do_write;
	logic do_read;

	assign rsp = rsp_q;

	always_comb begin
		for (int i = 0; i < NUM_DIRS; i++) begin
			nonempty[i] = (counts_q[i] != '0);
		end
	end

	// Round robin pick: keep the current direction while its burst lasts,
	// otherwise take the first non-empty queue from the search base on.
	always_comb begin
		limit = (burst_limit_q == '0) ? LIMIT_W'(1) : burst_limit_q;
		used = fresh_q ? '0 : burst_served_q;
		stay = !fresh_q && nonempty[cur_dir_q] && (used < limit);
		base = fresh_q ? start_dir_q : cur_dir_q + DIR_W'(1);
		found = stay;
		pick = cur_dir_q;
		for (int k = 0; k < NUM_DIRS; k++) begin
			probe = base + DIR_W'(k);
			if (!found && nonempty[probe]) begin
				found = 1'b1;
				pick = probe;
			end
		end
		new_served = stay ? used + LIMIT_W'(1) : LIMIT_W'(1);
	end

	always_comb begin
		enq_full = (counts_q[item_q.direction] == CW'(QUEUE_DEPTH));
		tail_sum = (SW + 1)'(heads_q[item_q.direction]) +
			(SW + 1)'(counts_q[item_q.direction]);
		if (tail_sum >= (SW + 1)'(QUEUE_DEPTH)) begin
			tail_slot = SW'(tail_sum - (SW + 1)'(QUEUE_DEPTH));
		end else begin
			tail_slot = SW'(tail_sum);
		end
		if (heads_q[pick] == SW'(QUEUE_DEPTH - 1)) begin
			head_next = '0;
		end else begin
			head_next = heads_q[pick] + SW'(1);
		end
		do_write = cmd.execute && (item_q.operation == OP_ENQUEUE) && !enq_full;
		do_read = cmd.execute && (item_q.operation == OP_SERVE) && found;
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[{item_q.direction, tail_slot}] <= {item_q.car_tag, item_q.pass_time};
		end
		if (do_read) begin
			rdata_q <= mem[AW'({pick, heads_q[pick]})];
		end
		if (cmd.load_item) begin
			item_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_dir_q <= '0;
			burst_limit_q <= LIMIT_W'(1);
			for (int i = 0; i < NUM_DIRS; i++) begin
				heads_q[i] <= '0;
				counts_q[i] <= '0;
			end
			cur_dir_q <= '0;
			burst_served_q <= '0;
			fresh_q <= 1'b1;
			status_q <= ST_EMPTY;
			pick_dir_q <= '0;
			rsp_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_START_DIRECTION: start_dir_q <= cfg_data[DIR_W-1:0];
					REG_BURST_LIMIT: burst_limit_q <= cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.execute) begin
				pick_dir_q <= pick;
				if (item_q.operation == OP_ENQUEUE) begin
					if (enq_full) begin
						status_q <= ST_DROPPED;
					end else begin
						status_q <= ST_ENQUEUED;
						counts_q[item_q.direction] <= counts_q[item_q.direction] + CW'(1);
					end
				end else if (found) begin
					status_q <= ST_GRANTED;
					heads_q[pick] <= head_next;
					counts_q[pick] <= counts_q[pick] - CW'(1);
					cur_dir_q <= pick;
					burst_served_q <= new_served;
					fresh_q <= 1'b0;
				end else begin
					status_q <= ST_EMPTY;
				end
			end
			if (cmd.load_out) begin
				rsp_q.status <= status_q;
				if (status_q == ST_GRANTED) begin
					rsp_q.granted_direction <= pick_dir_q;
					rsp_q.granted_tag <= rdata_q[ENTRY_W-1:TIME_W];
					rsp_q.granted_time <= rdata_q[TIME_W-1:0];
				end else begin
					rsp_q.granted_direction <= '0;
					rsp_q.granted_tag <= '0;
					rsp_q.granted_time <= '0;
				end
			end
		end
	end

endmodule

// ----- src/burst_limited_round_robin_queues_unit.sv -----
// Top level of the burst limited round robin queues unit.
// A result transaction is offered once its request has been accepted and has passed the
// execute and output steps of the controller, the output step waiting while an earlier result
// is not yet taken. Requests go one at a time; the car store read takes the execute step.
// Reset (arst_n low, asynchronous) empties all queues, clears burst state and sets the
// registers to start_direction 0 and burst_limit 1; the car store itself is not cleared.
module burst_limited_round_robin_queues_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input brlrr_pkg::req_item_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output brlrr_pkg::rsp_item_t rsp,
	input logic cfg_we,
	input logic [brlrr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [brlrr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import brlrr_pkg::*;

	// Commands from the controller to the datapath. The controller sequences each
	// transaction through capture, execution and handoff to the result register.
	dp_cmd_t cmd;

	// The controller owns the handshakes. A new request is taken whenever it is idle,
	// even while an earlier result still waits in the result register.
	brlrr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.cmd(cmd)
	);

	// The datapath holds the queues, the round robin and burst state, the
	// configuration registers and the registered result.
	brlrr_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

endmodule
